/* rtl/core/energy_vad_endpoint_detector_assert.svh */
// Assertion macros for the energy detector.
// Each macro takes a label, a clock, an active-low reset, an antecedent
// and a consequent.
`ifndef ENERGY_VAD_ENDPOINT_DETECTOR_ASSERT_SVH
`define ENERGY_VAD_ENDPOINT_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define EVAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evad assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EVAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evad assertion failed");

`else

`define EVAD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EVAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/evad_pkg.sv */
package evad_pkg;

  localparam int MAX_FRAME_SAMPLES = 1024;
  localparam int HANG_FRAMES       = 12;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int TIME_W   = 32;
  localparam int HANG_W   = 4;
  localparam int FLAG_W   = 3;

  // Sample counter must hold MAX_FRAME_SAMPLES itself.
  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  // Both sums hold up to MAX_FRAME_SAMPLES values of 16 bits each.
  localparam int ACC_W = SAMPLE_W + CNT_W - 1;

  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_FRAME_SAMPLES);
  localparam logic [HANG_W-1:0] HANG_LOAD = HANG_W'(HANG_FRAMES);

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_FRAMES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_INPUT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMERS_ENABLE    = 3'd5;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] RST_ENERGY_THRESHOLD = 16'd400;
  localparam logic [CFG_W-1:0] RST_SILENCE_FRAMES   = 16'd35;
  localparam logic [CFG_W-1:0] RST_LISTEN_FRAMES    = 16'd1;
  localparam logic [CFG_W-1:0] RST_NO_INPUT_TIMEOUT = 16'd4000;
  localparam logic [CFG_W-1:0] RST_SPEECH_TIMEOUT   = 16'd1000;

  // Latched flag bit positions.
  localparam int FLAG_STARTED  = 0;
  localparam int FLAG_SPEECH_TO = 1;
  localparam int FLAG_NOINPUT_TO = 2;

  typedef struct packed {
    logic [CFG_W-1:0] energy_threshold;
    logic [CFG_W-1:0] silence_frames;
    logic [CFG_W-1:0] listen_frames;
    logic [CFG_W-1:0] no_input_timeout_ms;
    logic [CFG_W-1:0] speech_timeout_ms;
    logic             timers_enable;
  } evad_cfg_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    logic [TIME_W-1:0]          now_ms;
  } evad_item_t;

  typedef struct packed {
    logic eval;
    logic loud;
  } evad_frame_t;

  typedef struct packed {
    logic stop;
    logic barge;
    logic speech_started;
    logic speech_timed_out;
    logic no_input_timed_out;
    logic listening;
  } evad_result_t;

endpackage

/* rtl/core/energy_vad_endpoint_detector.sv */
// Channel  Direction  Handshake          Beat contents
// in_      input      in_valid/in_stall  command, sample, frame_end, now_ms
// out_     output     out_valid/out_stall stop, barge, speech_started,
//                                         speech_timed_out, no_input_timed_out,
//                                         listening
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One input beat is taken every cycle while in_stall is low. A beat passes
// an input register and is processed there; the output register then takes
// its result for out_. A single pass of accumulate, compare and state update
// lies between the two registers. Reset is synchronous and active low and
// loads the register defaults. A stalled result holds in the output register
// while the input register still takes one more beat; beats that make no
// result never wait in the input register.

`include "energy_vad_endpoint_detector_assert.svh"

module energy_vad_endpoint_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic signed [evad_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_frame_end,
  input  logic [evad_pkg::TIME_W-1:0]           in_now_ms,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_stop,
  output logic                                  out_barge,
  output logic                                  out_speech_started,
  output logic                                  out_speech_timed_out,
  output logic                                  out_no_input_timed_out,
  output logic                                  out_listening,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [evad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [evad_pkg::CFG_W-1:0]            cfg_data
);

  // Configuration registers. Writes are taken in any cycle.
  evad_pkg::evad_cfg_t cfg_r, cfg_nxt;
  logic                cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (cfg_index)
        evad_pkg::REG_ENERGY_THRESHOLD: cfg_nxt.energy_threshold    = cfg_data;
        evad_pkg::REG_SILENCE_FRAMES:   cfg_nxt.silence_frames      = cfg_data;
        evad_pkg::REG_LISTEN_FRAMES:    cfg_nxt.listen_frames       = cfg_data;
        evad_pkg::REG_NO_INPUT_TIMEOUT: cfg_nxt.no_input_timeout_ms = cfg_data;
        evad_pkg::REG_SPEECH_TIMEOUT:   cfg_nxt.speech_timeout_ms   = cfg_data;
        evad_pkg::REG_TIMERS_ENABLE:    cfg_nxt.timers_enable       = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold    <= evad_pkg::RST_ENERGY_THRESHOLD;
      cfg_r.silence_frames      <= evad_pkg::RST_SILENCE_FRAMES;
      cfg_r.listen_frames       <= evad_pkg::RST_LISTEN_FRAMES;
      cfg_r.no_input_timeout_ms <= evad_pkg::RST_NO_INPUT_TIMEOUT;
      cfg_r.speech_timeout_ms   <= evad_pkg::RST_SPEECH_TIMEOUT;
      cfg_r.timers_enable       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register.
  evad_pkg::evad_item_t   s1_item_r;
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   in_accept;
  logic                   s1_has_result;
  logic                   s1_adv;

  // Output register.
  evad_pkg::evad_result_t out_res_r;
  evad_pkg::evad_result_t result;
  evad_pkg::evad_frame_t  frame;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;

  // Only an audio beat that closes a frame makes a result; everything else
  // retires without touching the output register.
  assign s1_has_result = !s1_item_r.command && s1_item_r.frame_end;
  assign s1_adv        = s1_valid_r && (!s1_has_result || !out_valid_r || !out_stall);
  assign out_load      = s1_adv && s1_has_result;

  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.command   <= in_command;
      s1_item_r.sample    <= in_sample;
      s1_item_r.frame_end <= in_frame_end;
      s1_item_r.now_ms    <= in_now_ms;
    end
    if (out_load) begin
      out_res_r <= result;
    end
  end

  // Frame sums and loud decision.
  evad_accum u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_adv),
    .item             (s1_item_r),
    .energy_threshold (cfg_r.energy_threshold),
    .frame            (frame)
  );

  // Loud and quiet counting, hang countdown, timeouts and latched flags.
  evad_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_item_r),
    .frame  (frame),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_valid              = out_valid_r;
  assign out_stop               = out_res_r.stop;
  assign out_barge              = out_res_r.barge;
  assign out_speech_started     = out_res_r.speech_started;
  assign out_speech_timed_out   = out_res_r.speech_timed_out;
  assign out_no_input_timed_out = out_res_r.no_input_timed_out;
  assign out_listening          = out_res_r.listening;

  // Barge-in always comes with speech started and a nonzero loud count.
  `EVAD_ASSERT_NOW(a_barge_flags, clk, rst_n, out_valid && out_barge,
                   out_speech_started && out_listening)
  // A loud frame clears the silence timer, so barge-in never ends an utterance.
  `EVAD_ASSERT_NOW(a_barge_no_stop, clk, rst_n, out_valid && out_barge, !out_stop)
  // The input side only stalls while the input register holds a waiting beat.
  `EVAD_ASSERT_NOW(a_stall_held, clk, rst_n, in_stall, s1_valid_r && s1_has_result)
  // A frame result that leaves the input register shows on the output next cycle.
  `EVAD_ASSERT_NEXT(a_result_shown, clk, rst_n, out_load, out_valid)

endmodule

/* rtl/core/evad_accum.sv */
module evad_accum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  evad_pkg::evad_item_t             item,
  input  logic [evad_pkg::CFG_W-1:0]       energy_threshold,
  output evad_pkg::evad_frame_t            frame
);

  logic [evad_pkg::ACC_W-1:0]    amp_sum_r, amp_sum_nxt;
  logic [evad_pkg::ACC_W-1:0]    thr_sum_r, thr_sum_nxt;
  logic [evad_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [evad_pkg::SAMPLE_W-1:0] raw;
  logic [evad_pkg::SAMPLE_W-1:0] mag;
  logic [evad_pkg::ACC_W-1:0]    amp_add, thr_add;
  logic                          room;

  assign raw  = item.sample;
  // Two's complement magnitude; the most negative sample maps to 0x8000.
  assign mag  = raw[evad_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;
  assign room = count_r < evad_pkg::MAX_CNT;

  assign amp_add = room ? amp_sum_r + evad_pkg::ACC_W'(mag) : amp_sum_r;
  assign thr_add = room ? thr_sum_r + evad_pkg::ACC_W'(energy_threshold) : thr_sum_r;

  assign frame.eval = !item.command && item.frame_end;
  assign frame.loud = amp_add >= thr_add;

  always_comb begin
    amp_sum_nxt = amp_sum_r;
    thr_sum_nxt = thr_sum_r;
    count_nxt   = count_r;
    if (step && !item.command) begin
      if (item.frame_end) begin
        amp_sum_nxt = '0;
        thr_sum_nxt = '0;
        count_nxt   = '0;
      end else begin
        amp_sum_nxt = amp_add;
        thr_sum_nxt = thr_add;
        if (room) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_sum_r <= '0;
      thr_sum_r <= '0;
      count_r   <= '0;
    end else begin
      amp_sum_r <= amp_sum_nxt;
      thr_sum_r <= thr_sum_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

/* rtl/core/evad_ctrl.sv */
module evad_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  evad_pkg::evad_item_t  item,
  input  evad_pkg::evad_frame_t frame,
  input  evad_pkg::evad_cfg_t   cfg,
  output evad_pkg::evad_result_t result
);

  logic [evad_pkg::CFG_W-1:0]  loud_count_r, loud_count_nxt;
  logic [evad_pkg::CFG_W-1:0]  quiet_left_r, quiet_left_nxt;
  logic [evad_pkg::HANG_W-1:0] hang_left_r, hang_left_nxt;
  logic [evad_pkg::TIME_W-1:0] silence_start_r, silence_start_nxt;
  logic                        silence_running_r, silence_running_nxt;
  logic [evad_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic [evad_pkg::TIME_W-1:0] elapsed;
  logic                        stop, barge, timed_out;

  always_comb begin
    loud_count_nxt      = loud_count_r;
    quiet_left_nxt      = quiet_left_r;
    hang_left_nxt       = hang_left_r;
    silence_start_nxt   = silence_start_r;
    silence_running_nxt = silence_running_r;
    flags_nxt           = flags_r;
    elapsed             = '0;
    stop                = 1'b0;
    barge               = 1'b0;
    timed_out           = 1'b0;
    if (step) begin
      if (item.command) begin
        flags_nxt           = '0;
        silence_start_nxt   = item.now_ms;
        silence_running_nxt = 1'b1;
      end else if (frame.eval) begin
        if (hang_left_r != '0) begin
          // Hang countdown: the frame itself is not judged.
          hang_left_nxt = hang_left_r - 1'b1;
          if (hang_left_nxt == '0) begin
            quiet_left_nxt = cfg.silence_frames;
            loud_count_nxt = '0;
            stop           = 1'b1;
          end
        end else begin
          if (frame.loud) begin
            if (loud_count_r != '1) begin
              loud_count_nxt = loud_count_r + 1'b1;
              if (loud_count_r == '0) begin
                barge                             = 1'b1;
                flags_nxt[evad_pkg::FLAG_STARTED] = 1'b1;
              end
            end
            silence_running_nxt = 1'b0;
          end else if (!silence_running_r) begin
            silence_start_nxt   = item.now_ms;
            silence_running_nxt = 1'b1;
          end

          elapsed = item.now_ms - silence_start_nxt;
          if (silence_running_nxt && cfg.timers_enable) begin
            if (flags_nxt[evad_pkg::FLAG_STARTED]) begin
              if (cfg.speech_timeout_ms != '0 && !flags_nxt[evad_pkg::FLAG_SPEECH_TO] &&
                  elapsed >= evad_pkg::TIME_W'(cfg.speech_timeout_ms)) begin
                flags_nxt[evad_pkg::FLAG_SPEECH_TO] = 1'b1;
                timed_out                           = 1'b1;
              end
            end else begin
              if (cfg.no_input_timeout_ms != '0 && !flags_nxt[evad_pkg::FLAG_NOINPUT_TO] &&
                  elapsed >= evad_pkg::TIME_W'(cfg.no_input_timeout_ms)) begin
                flags_nxt[evad_pkg::FLAG_NOINPUT_TO] = 1'b1;
                timed_out                            = 1'b1;
              end
            end
          end

          if (timed_out) begin
            // A timeout ends the utterance and skips quiet frame counting.
            loud_count_nxt = '0;
            stop           = 1'b1;
          end else if (loud_count_nxt > cfg.listen_frames && !frame.loud) begin
            if (quiet_left_r <= 16'd1) begin
              quiet_left_nxt = '0;
              hang_left_nxt  = evad_pkg::HANG_LOAD;
            end else begin
              quiet_left_nxt = quiet_left_r - 1'b1;
            end
          end else begin
            quiet_left_nxt = cfg.silence_frames;
          end
        end
      end
    end
  end

  assign result.stop               = stop;
  assign result.barge              = barge;
  assign result.speech_started     = flags_nxt[evad_pkg::FLAG_STARTED];
  assign result.speech_timed_out   = flags_nxt[evad_pkg::FLAG_SPEECH_TO];
  assign result.no_input_timed_out = flags_nxt[evad_pkg::FLAG_NOINPUT_TO];
  assign result.listening          = loud_count_nxt != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_count_r      <= '0;
      quiet_left_r      <= evad_pkg::RST_SILENCE_FRAMES;
      hang_left_r       <= '0;
      silence_start_r   <= '0;
      silence_running_r <= 1'b0;
      flags_r           <= '0;
    end else begin
      loud_count_r      <= loud_count_nxt;
      quiet_left_r      <= quiet_left_nxt;
      hang_left_r       <= hang_left_nxt;
      silence_start_r   <= silence_start_nxt;
      silence_running_r <= silence_running_nxt;
      flags_r           <= flags_nxt;
    end
  end

endmodule
